// ----- rtl/packet_framer_stop_and_wait_defines.svh -----
// ----------------------------------------------------------------------------
// Packet framer assertion macros
// Shorthand for the concurrent checks in the framer's top level.
// ----------------------------------------------------------------------------
`ifndef PACKET_FRAMER_STOP_AND_WAIT_DEFINES_SVH
`define PACKET_FRAMER_STOP_AND_WAIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PFSW_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFSW_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pfsw_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet framer package
// Sizes, operation and link-state codes, and the records passed between units.
// ----------------------------------------------------------------------------
package pfsw_pkg;

  localparam int CHUNK_BYTES = 1024;
  localparam int LEN_W  = $clog2(CHUNK_BYTES + 1);
  localparam int IDX_W  = $clog2(CHUNK_BYTES + 4);
  localparam int ADDR_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

  localparam logic [LEN_W-1:0] CHUNK_LEN = LEN_W'(CHUNK_BYTES);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [7:0] RETRY_LIMIT_RESET = 8'd3;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_PULL    = 3'd1,
    OP_ACK     = 3'd2,
    OP_NAK     = 3'd3,
    OP_TIMEOUT = 3'd4,
    OP_UNKNOWN = 3'd5
  } op_t;

  localparam logic [1:0] LINK_COLLECT = 2'd0;
  localparam logic [1:0] LINK_SEND    = 2'd1;
  localparam logic [1:0] LINK_WAIT    = 2'd2;
  localparam logic [1:0] LINK_FAILED  = 2'd3;

  // One result item
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [1:0]  link_state;
    logic [15:0] packet_number;
    logic [7:0]  retry_count;
    logic        rejected;
  } res_t;

  // Front to back: result with byte taken from the buffer when use_mem
  typedef struct packed {
    logic use_mem;
    res_t res;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

endpackage

// ----- rtl/packet_framer_stop_and_wait.sv -----
// ----------------------------------------------------------------------------
// Packet framer with stop-and-wait retry
// Frames payload chunks with number and checksum trailer, replays on failure.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low and returns exactly one
// result item for each, in order. After an item is accepted, the front end
// updates the link state and reads the payload buffer (a single-port-read RAM
// with registered data); the read byte is then merged and the result written
// to the result queue. The four-entry result queue lets the output side stall
// without stopping input; in_stall rises only when the queue plus the item in
// flight fill it. The 4-byte trailer (packet number, then checksum, both
// little-endian) is never stored, it is rebuilt from the number and sum
// registers on each pull. retry_limit is written through cfg_write/cfg_data and
// should only change while no results are pending. No clearing pass is needed
// after reset: the buffer is read only below the loaded length.
// ----------------------------------------------------------------------------
`include "packet_framer_stop_and_wait_defines.svh"

module packet_framer_stop_and_wait import pfsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic [1:0]  link_state,
  output logic [15:0] packet_number,
  output logic [7:0]  retry_count,
  output logic        rejected
);

  logic              space;
  logic              take;
  buf_wr_t           wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              job_valid;
  job_t              job;
  res_t              out_res;
  logic              shown_fail;

  assign in_stall = !space;
  assign take     = in_valid && space;

  // front: state, classification, buffer write and read issue
  pfsw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .take      (take),
    .operation (operation),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .job_valid (job_valid),
    .job       (job)
  );

  // payload store, trailer is not kept here
  pfsw_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // back: byte merge and result queue
  pfsw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .rd_data   (rd_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .space     (space)
  );

  assign tx_valid      = out_res.tx_valid;
  assign tx_byte       = out_res.tx_byte;
  assign tx_last       = out_res.tx_last;
  assign link_state    = out_res.link_state;
  assign packet_number = out_res.packet_number;
  assign retry_count   = out_res.retry_count;
  assign rejected      = out_res.rejected;

  // checks
  assign shown_fail = out_valid && link_state == LINK_FAILED;

  `PFSW_ASSERT_NOW(a_last_needs_byte, clk, rst, out_valid && tx_last, tx_valid, "lone tx_last")
  `PFSW_ASSERT_NOW(a_reject_no_byte, clk, rst, out_valid && rejected, !tx_valid, "byte on reject")
  `PFSW_ASSERT_NOW(a_fail_counted, clk, rst, shown_fail, retry_count != '0, "no counted try")
  `PFSW_ASSERT_NEXT(a_hold_res, clk, rst, out_valid && out_stall, $stable(out_res), "item changed")

endmodule

// ----- rtl/pfsw_buf.sv -----
// ----------------------------------------------------------------------------
// Packet framer payload buffer
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfsw_buf import pfsw_pkg::*; (
  input  logic              clk,
  input  buf_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [CHUNK_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/pfsw_front.sv -----
// ----------------------------------------------------------------------------
// Packet framer front end
// Accepts items, runs the framing and retry state, issues buffer accesses.
// ----------------------------------------------------------------------------
module pfsw_front import pfsw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data,
  input  logic              take,
  input  logic [2:0]        operation,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output buf_wr_t           wr,
  output logic [ADDR_W-1:0] rd_addr,
  output logic              job_valid,
  output job_t              job
);

  typedef enum logic [1:0] {
    PH_COLLECT = LINK_COLLECT,
    PH_SEND    = LINK_SEND,
    PH_WAIT    = LINK_WAIT,
    PH_FAIL    = LINK_FAILED
  } phase_t;

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  payload_length, payload_length_next;
  logic [IDX_W-1:0]  send_index, send_index_next;
  logic [15:0]       running_sum, running_sum_next;
  logic [15:0]       sequence_number, sequence_number_next;
  logic [7:0]        attempt_count, attempt_count_next;
  logic [7:0]        retry_limit;

  logic [15:0]       byte_sum;
  logic [15:0]       closed_sum;
  logic [LEN_W-1:0]  len_inc;
  logic [IDX_W-1:0]  len_ext;
  logic [IDX_W-1:0]  final_idx;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  trl_off;
  logic [7:0]        trl_byte;
  logic [7:0]        cnt_inc;
  logic              rej;

  always_comb begin
    byte_sum   = running_sum + {8'd0, data_byte};
    closed_sum = byte_sum + {8'd0, sequence_number[7:0]} + {8'd0, sequence_number[15:8]};
    len_inc    = payload_length + 1'b1;
    len_ext    = IDX_W'(payload_length);
    final_idx  = len_ext + IDX_W'(3);
    idx        = (send_index > final_idx) ? final_idx : send_index;
    trl_off    = idx - len_ext;
    cnt_inc    = (attempt_count == 8'hff) ? attempt_count : attempt_count + 8'd1;

    // trailer: number lo/hi, then sum lo/hi (sum already holds the number)
    case (trl_off[1:0])
      2'd0:    trl_byte = sequence_number[7:0];
      2'd1:    trl_byte = sequence_number[15:8];
      2'd2:    trl_byte = running_sum[7:0];
      default: trl_byte = running_sum[15:8];
    endcase
  end

  always_comb begin
    phase_next           = phase;
    payload_length_next  = payload_length;
    send_index_next      = send_index;
    running_sum_next     = running_sum;
    sequence_number_next = sequence_number;
    attempt_count_next   = attempt_count;
    rej                  = 1'b0;
    wr.en                = 1'b0;
    wr.addr              = payload_length[ADDR_W-1:0];
    wr.data              = data_byte;
    job                  = '0;

    unique case (op_t'(operation))
      OP_LOAD: begin
        if (phase == PH_COLLECT) begin
          wr.en               = take;
          running_sum_next    = byte_sum;
          payload_length_next = len_inc;
          if (last_byte || len_inc >= CHUNK_LEN) begin
            running_sum_next = closed_sum;
            send_index_next  = '0;
            phase_next       = PH_SEND;
          end
        end else begin
          rej = 1'b1;
        end
      end
      OP_PULL: begin
        if (phase == PH_SEND) begin
          job.res.tx_valid = 1'b1;
          job.use_mem      = idx < len_ext;
          job.res.tx_byte  = trl_byte;
          if (idx == final_idx) begin
            job.res.tx_last = 1'b1;
            phase_next      = PH_WAIT;
          end else begin
            send_index_next = idx + 1'b1;
          end
        end else begin
          rej = 1'b1;
        end
      end
      OP_ACK: begin
        if (phase == PH_WAIT) begin
          attempt_count_next   = '0;
          sequence_number_next = sequence_number + 16'd1;
          payload_length_next  = '0;
          running_sum_next     = '0;
          send_index_next      = '0;
          phase_next           = PH_COLLECT;
        end else begin
          rej = 1'b1;
        end
      end
      OP_NAK, OP_TIMEOUT: begin
        if (phase == PH_WAIT) begin
          attempt_count_next = cnt_inc;
          if (cnt_inc >= retry_limit) begin
            phase_next = PH_FAIL;
          end else begin
            send_index_next = '0;
            phase_next      = PH_SEND;
          end
        end else begin
          rej = 1'b1;
        end
      end
      OP_UNKNOWN: begin
        if (phase == PH_WAIT) begin
          send_index_next = '0;
          phase_next      = PH_SEND;
        end else begin
          rej = 1'b1;
        end
      end
      default: rej = 1'b1;
    endcase

    if (rej) begin
      phase_next           = phase;
      payload_length_next  = payload_length;
      send_index_next      = send_index;
      running_sum_next     = running_sum;
      sequence_number_next = sequence_number;
      attempt_count_next   = attempt_count;
      job                  = '0;
    end

    job.res.rejected      = rej;
    job.res.link_state    = phase_next;
    job.res.packet_number = sequence_number_next;
    job.res.retry_count   = attempt_count_next;
  end

  assign rd_addr   = idx[ADDR_W-1:0];
  assign job_valid = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COLLECT;
      payload_length  <= '0;
      send_index      <= '0;
      running_sum     <= '0;
      sequence_number <= '0;
      attempt_count   <= '0;
      retry_limit     <= RETRY_LIMIT_RESET;
    end else begin
      if (take) begin
        phase           <= phase_next;
        payload_length  <= payload_length_next;
        send_index      <= send_index_next;
        running_sum     <= running_sum_next;
        sequence_number <= sequence_number_next;
        attempt_count   <= attempt_count_next;
      end
      if (cfg_write) begin
        retry_limit <= cfg_data;
      end
    end
  end

endmodule

// ----- rtl/pfsw_back.sv -----
// ----------------------------------------------------------------------------
// Packet framer back end
// Merges buffer read data into the result and queues results for output.
// ----------------------------------------------------------------------------
module pfsw_back import pfsw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  input  logic [7:0] rd_data,
  input  logic       out_stall,
  output logic       out_valid,
  output res_t       out_res,
  output logic       space
);

  logic              s1_valid;
  job_t              s1_job;
  res_t              s1_res;
  res_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] head, tail;
  logic [QCNT_W-1:0] count, count_next;
  logic              pop;

  // rd_data and s1_job are both registered, so the read byte lines up with its job in the cycle after issue
  always_comb begin
    s1_res = s1_job.res;
    if (s1_job.use_mem) begin
      s1_res.tx_byte = rd_data;
    end
  end

  assign out_valid = count != '0;
  assign out_res   = q_mem[head];
  assign pop       = out_valid && !out_stall;
  assign count_next = count + QCNT_W'(s1_valid) - QCNT_W'(pop);
  // reserve room for the item in flight
  assign space     = (count + QCNT_W'(s1_valid)) < QCNT_W'(QDEPTH);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q_mem[tail] <= s1_res;
    end
    s1_job <= job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
    end else begin
      s1_valid <= job_valid;
      count    <= count_next;
      if (s1_valid) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
    end
  end

endmodule
